@@ design/hskr_pkg.sv @@
// Shared types, widths and helpers for the highlight roll-off block.
`timescale 1ns / 1ps
`default_nettype none
package hskr_pkg;

  localparam int SAMPLE_W = 18;
  localparam int AMOUNT_W = 11;
  localparam int TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

  localparam logic [AMOUNT_W-1:0] AMOUNT_FULL = 11'd1024;

  typedef enum logic [1:0] {
    REG_PASS,
    REG_KNEE,
    REG_TAIL
  } region_t;

  // Floor divide by five through the reciprocal, exact for any 32-bit value.
  function automatic logic [31:0] div5(input logic [31:0] v);
    logic [63:0] prod;
    prod = {32'd0, v} * 64'h0000_0000_CCCC_CCCD;
    return {2'b00, prod[63:34]};
  endfunction

endpackage
`default_nettype wire

@@ design/highlight_soft_knee_rolloff_unit.sv @@
// Top level of the highlight soft-knee roll-off pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Highlight roll-off on a stream of signed Q3.14 samples (1.0 = 16384 at the
// default FRAC_BITS). Samples below the threshold pass, samples in the knee
// follow a cubic Hermite segment, samples beyond it ease toward the point
// halfway between the exit level and 1.0 along a tanh curve read from an
// interpolated table, and the result is blended with the input by the
// amount register and saturated. One item enters per clock; the divider
// resolves one quotient bit per stage. A stall on the master side holds the
// whole pipeline in place. After each amount write, and after reset, the
// slave side stays closed while the derived threshold, knee, exit level and
// scale move through their own register steps.
module highlight_soft_knee_rolloff_unit #(
  parameter int FRAC_BITS        = 14,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [hskr_pkg::AMOUNT_W-1:0] cfg_wdata,      // rolloff_amount
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hskr_pkg::TDATA_W-1:0]  s_axis_tdata,   // [17:0] sample_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hskr_pkg::TDATA_W-1:0]  m_axis_tdata    // [17:0] sample_out
);
  import hskr_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VW  = F + 1;
  localparam int TW  = F + 1;
  localparam int EW  = ((F + 1 > SAMPLE_W) ? F + 1 : SAMPLE_W) + 2;
  localparam int QB  = F + 2;
  localparam int HW  = 3 * VW + 3;
  localparam int D5W = 2 * VW + 3;
  localparam int DW  = D5W + 1;
  localparam int NW  = ((HW + 2 > EW + F + 1) ? HW + 2 : EW + F + 1);
  localparam int IW  = $clog2(TANH_TABLE_DEPTH);
  localparam int PW  = QB + $clog2(TANH_TABLE_DEPTH + 1);
  localparam int PRW = VW + TW + 1;
  localparam int MW  = EW + 13;
  localparam int RSW = MW + 1;

  localparam logic [VW-1:0] ONE_V = {1'b1, {F{1'b0}}};
  localparam logic signed [RSW-1:0] RMAX = RSW'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [RSW-1:0] RMIN = -RSW'(2 ** (SAMPLE_W - 1));

  typedef struct packed {
    region_t                    region;
    logic                       neg;
    logic signed [SAMPLE_W-1:0] x;
    logic [VW-1:0]              u;
  } dside_t;

  typedef struct packed {
    region_t                    region;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [EW-1:0]       c;
  } tside_t;

  // Derived curve values from the amount register.
  logic [AMOUNT_W-1:0] amt;
  logic [VW-1:0]       thr, knee, pexit, s2;
  logic [D5W-1:0]      d5kk;
  logic                cfg_busy;

  hskr_cfg #(.FRAC_BITS(F)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .amt       (amt),
    .thr       (thr),
    .knee      (knee),
    .pexit     (pexit),
    .s2        (s2),
    .d5kk      (d5kk),
    .busy      (cfg_busy)
  );

  // Every stage advances together unless the output register holds an
  // item that has not been taken.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !cfg_busy;

  // Stage 0: capture the sample.
  logic                       v0;
  logic signed [SAMPLE_W-1:0] x0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0 <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
    end
  end

  // Stage 1: offset from the threshold and the region the sample falls in.
  logic                       v1;
  logic signed [SAMPLE_W-1:0] x1;
  logic signed [EW-1:0]       u1;
  region_t                    region1;
  logic signed [EW-1:0]       u1_next;
  region_t                    region1_next;

  always_comb begin
    u1_next = EW'(x0) - $signed(EW'(thr));
    if (u1_next < 0) begin
      region1_next = REG_PASS;
    end else if (u1_next < $signed(EW'(knee))) begin
      region1_next = REG_KNEE;
    end else begin
      region1_next = REG_TAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1      <= x0;
      u1      <= u1_next;
      region1 <= region1_next;
    end
  end

  // Stage 2: square of the knee offset, the Hermite slope term and the
  // distance past the knee.
  logic                       v2;
  logic signed [SAMPLE_W-1:0] x2;
  logic [VW-1:0]              u2;
  logic [2*VW-1:0]            uu2;
  logic signed [VW+1:0]       kd2;
  logic signed [EW-1:0]       e2;
  region_t                    region2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2      <= x1;
      u2      <= u1[VW-1:0];
      uu2     <= u1[VW-1:0] * u1[VW-1:0];
      kd2     <= $signed({2'b00, knee}) - $signed({1'b0, u1[VW-1:0], 1'b0});
      e2      <= u1 - $signed(EW'(knee));
      region2 <= region1;
    end
  end

  // Stage 3: full Hermite numerator u*u*(K - 2u).
  logic                       v3;
  logic signed [SAMPLE_W-1:0] x3;
  logic [VW-1:0]              u3;
  logic signed [HW-1:0]       hn3;
  logic signed [EW-1:0]       e3;
  region_t                    region3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x3      <= x2;
      u3      <= u2;
      hn3     <= HW'($signed({1'b0, uu2}) * kd2);
      e3      <= e2;
      region3 <= region2;
    end
  end

  // Stage 4: load the divider. In the knee, round the Hermite term to
  // nearest on its magnitude; past the knee, form the tanh argument.
  logic           v4;
  logic [NW-1:0]  num4;
  logic [DW-1:0]  den4;
  dside_t         side4;
  logic           neg3;
  logic [HW-1:0]  mag3;
  logic [NW-1:0]  num4_next;
  logic [DW-1:0]  den4_next;

  always_comb begin
    neg3 = hn3 < 0;
    mag3 = neg3 ? HW'(-hn3) : HW'(hn3);
    if (region3 == REG_TAIL) begin
      num4_next = NW'(e3[EW-2:0]) << (F + 1);
      den4_next = DW'(s2);
    end else begin
      num4_next = (NW'(mag3) << 1) + NW'(d5kk);
      den4_next = {d5kk, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num4         <= num4_next;
      den4         <= den4_next;
      side4.region <= region3;
      side4.neg    <= neg3;
      side4.x      <= x3;
      side4.u      <= u3;
    end
  end

  logic          dv_valid;
  logic [QB-1:0] dv_quo;
  logic          dv_sat;
  dside_t        dv_side;

  hskr_div #(
    .NW (NW),
    .DW (DW),
    .QB (QB),
    .SW ($bits(dside_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v4),
    .in_num    (num4),
    .in_den    (den4),
    .in_side   (side4),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_sat   (dv_sat),
    .out_side  (dv_side)
  );

  // Stage 5: finish the knee curve, and split the tanh argument into a
  // table index and an interpolation fraction.
  logic                 v5;
  logic [IW-1:0]        idx5;
  logic [QB-1:0]        frac5;
  logic                 sat5;
  tside_t               side5;
  logic signed [QB:0]   hq;
  logic [PW-1:0]        pos;
  logic signed [EW-1:0] c5_next;

  always_comb begin
    hq  = dv_side.neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    pos = PW'(dv_quo) * PW'(TANH_TABLE_DEPTH);
    unique case (dv_side.region)
      REG_KNEE: c5_next = $signed(EW'(thr)) + $signed(EW'(dv_side.u)) + EW'(hq);
      default:  c5_next = EW'(dv_side.x);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx5         <= IW'(pos >> QB);
      frac5        <= pos[QB-1:0];
      sat5         <= dv_sat;
      side5.region <= dv_side.region;
      side5.x      <= dv_side.x;
      side5.c      <= c5_next;
    end
  end

  logic          tn_valid;
  logic [TW-1:0] tq;
  tside_t        tn_side;

  hskr_tanh #(
    .FRAC_BITS        (F),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
    .SW               ($bits(tside_t))
  ) u_tanh (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .in_idx    (idx5),
    .in_frac   (frac5),
    .in_sat    (sat5),
    .in_side   (side5),
    .out_valid (tn_valid),
    .out_tq    (tq),
    .out_side  (tn_side)
  );

  // Stage 8: scale the tanh value by twice the asymptote scale.
  logic           v8;
  logic [PRW-1:0] prod8;
  tside_t         side8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= tn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod8 <= PRW'(s2) * PRW'(tq);
      side8 <= tn_side;
    end
  end

  // Stage 9: pick the curve value and take its distance from the input.
  logic                       v9;
  logic signed [SAMPLE_W-1:0] x9;
  logic signed [EW:0]         diff9;
  logic signed [EW-1:0]       c9;

  always_comb begin
    if (side8.region == REG_TAIL) begin
      c9 = $signed(EW'(pexit)) + $signed(EW'((prod8 + PRW'(ONE_V)) >> (F + 1)));
    end else begin
      c9 = side8.c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x9    <= side8.x;
      diff9 <= (EW+1)'(c9) - (EW+1)'(side8.x);
    end
  end

  // Stage 10: weight the distance by the amount.
  logic                       v10;
  logic signed [SAMPLE_W-1:0] x10;
  logic signed [MW-1:0]       m10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x10 <= x9;
      m10 <= MW'($signed({1'b0, amt}) * diff9);
    end
  end

  // Stage 11: round the blend to nearest, ties away from zero, saturate,
  // and hold it in the output register.
  logic                 neg10;
  logic [MW-1:0]        mag10;
  logic [MW-1:0]        q10;
  logic signed [RSW-1:0] r10;
  logic signed [SAMPLE_W-1:0] res10;

  always_comb begin
    neg10 = m10 < 0;
    mag10 = neg10 ? MW'(-m10) : MW'(m10);
    q10   = (mag10 + MW'(512)) >> 10;
    r10   = RSW'(x10) + (neg10 ? -$signed({1'b0, q10}) : $signed({1'b0, q10}));
    if (r10 > RMAX) begin
      res10 = RMAX[SAMPLE_W-1:0];
    end else if (r10 < RMIN) begin
      res10 = RMIN[SAMPLE_W-1:0];
    end else begin
      res10 = r10[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {(TDATA_W - SAMPLE_W)'(0), res10};
    end
  end

  // A new amount must keep the input closed while derived values settle.
  a_cfg_closes_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> !s_axis_tready)
    else $error("input opened right after an amount write");

  // The knee quotient is always far below the divider's range.
  a_knee_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (dv_valid && (dv_side.region == REG_KNEE)) |-> !dv_sat)
    else $error("knee division overflowed");

  // Interpolated tanh never exceeds 1.0.
  a_tanh_bounded: assert property (@(posedge clk) disable iff (rst)
    tn_valid |-> (tq <= ONE_V))
    else $error("tanh value above 1.0");

endmodule
`default_nettype wire

@@ design/hskr_cfg.sv @@
// Amount register and the derived curve values, with a settle window after a write.
`timescale 1ns / 1ps
`default_nettype none
module hskr_cfg #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [hskr_pkg::AMOUNT_W-1:0] cfg_wdata,
  output logic [hskr_pkg::AMOUNT_W-1:0] amt,
  output logic [FRAC_BITS:0]            thr,
  output logic [FRAC_BITS:0]            knee,
  output logic [FRAC_BITS:0]            pexit,
  output logic [FRAC_BITS:0]            s2,
  output logic [2*FRAC_BITS+4:0]        d5kk,
  output logic                          busy
);
  import hskr_pkg::*;

  localparam int VW  = FRAC_BITS + 1;
  localparam int D5W = 2 * VW + 3;
  localparam int CNW = FRAC_BITS + 15;
  localparam logic [2:0] SETTLE = 3'd4;
  localparam logic [VW-1:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};

  logic [AMOUNT_W-1:0] amount;
  logic [2:0]          settle;
  logic [2*VW-1:0]     kk;

  logic [13:0]    t_base;
  logic [13:0]    k_base;
  logic [CNW-1:0] t_num;
  logic [CNW-1:0] k_num;
  logic [VW+2:0]  p_num;
  logic [VW-1:0]  thr_next;
  logic [VW-1:0]  knee_next;
  logic [VW-1:0]  pexit_next;

  always_comb begin
    t_base     = 14'd8192 - ({3'b000, amt} + {2'b00, amt, 1'b0});
    k_base     = 14'd1536 + {3'b000, amt};
    t_num      = (CNW'(t_base) << FRAC_BITS) + CNW'(5120);
    k_num      = (CNW'(k_base) << FRAC_BITS) + CNW'(5120);
    thr_next   = VW'(div5(32'(t_num >> 11)));
    knee_next  = VW'(div5(32'(k_num >> 11)));
    p_num      = {knee, 3'b000} + (VW+3)'(5);
    pexit_next = thr + VW'(div5(32'(p_num >> 1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amount <= '0;
      settle <= SETTLE;
    end else if (cfg_wen) begin
      amount <= cfg_wdata;
      settle <= SETTLE;
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  // Four register steps from the amount to the last derived value.
  always_ff @(posedge clk) begin
    amt   <= (amount > AMOUNT_FULL) ? AMOUNT_FULL : amount;
    thr   <= thr_next;
    knee  <= knee_next;
    pexit <= pexit_next;
    kk    <= knee * knee;
    s2    <= ONE_V - pexit;
    d5kk  <= D5W'({kk, 2'b00}) + D5W'(kk);
  end

  assign busy = (settle != 3'd0);

endmodule
`default_nettype wire

@@ design/hskr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module hskr_div #(
  parameter int NW = 48,
  parameter int DW = 34,
  parameter int QB = 16,
  parameter int SW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_quo,
  output logic          out_sat,
  output logic [SW-1:0] out_side
);

  localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [RW-1:0] rem  [QB];
  logic [DW-1:0] den  [QB];
  logic [QB-1:0] quo  [QB+1];
  logic          sat  [QB+1];
  logic [SW-1:0] side [QB+1];
  logic          vld  [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // Stage zero flags a quotient that would not fit in QB bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RW'(in_num);
      den[0]  <= in_den;
      quo[0]  <= '0;
      sat[0]  <= RW'(in_num) >= (RW'(in_den) << QB);
      side[0] <= in_side;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [RW-1:0] sub;
    logic          take;

    always_comb begin
      sub  = RW'(den[i-1]) << (QB - i);
      take = rem[i-1] >= sub;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[i]  <= quo[i-1] | (take ? (QB'(1) << (QB - i)) : '0);
        sat[i]  <= sat[i-1];
        side[i] <= side[i-1];
      end
    end

    if (i < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= take ? (rem[i-1] - sub) : rem[i-1];
          den[i] <= den[i-1];
        end
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_quo   = quo[QB];
  assign out_sat   = sat[QB];
  assign out_side  = side[QB];

endmodule
`default_nettype wire

@@ design/hskr_tanh.sv @@
// Tanh lookup: table read, then linear interpolation between neighbor entries.
`timescale 1ns / 1ps
`default_nettype none
module hskr_tanh #(
  parameter int FRAC_BITS        = 14,
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int SW               = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [$clog2(TANH_TABLE_DEPTH)-1:0] in_idx,
  input  logic [FRAC_BITS+1:0]                in_frac,
  input  logic                                in_sat,
  input  logic [SW-1:0]                       in_side,
  output logic                                out_valid,
  output logic [FRAC_BITS:0]                  out_tq,
  output logic [SW-1:0]                       out_side
);

  localparam int TW = FRAC_BITS + 1;
  localparam int QB = FRAC_BITS + 2;
  localparam int MW = TW + QB + 1;
  localparam logic [63:0] STEP_Q = (64'd4 << 30) / TANH_TABLE_DEPTH;

  typedef logic [2*TW-1:0] rom_t [TANH_TABLE_DEPTH];

  // Shift-and-subtract quotient, evaluated only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Each entry holds {next - this, this} so one read serves the interpolation.
  function automatic rom_t build_rom();
    logic [63:0] one_v, step, p2, p3, p5, p7, dv, t, cur, prev;
    rom_t r;
    one_v = 64'd1 << 30;
    step  = STEP_Q;
    p2    = (step * step) >> 30;
    p3    = (p2 * step) >> 30;
    p5    = (p3 * p2) >> 30;
    p7    = (p5 * p2) >> 30;
    dv    = step - udiv64(p3, 64'd3) + udiv64(64'd2 * p5, 64'd15)
            - udiv64(64'd17 * p7, 64'd315);
    t     = '0;
    prev  = '0;
    for (int k = 1; k <= TANH_TABLE_DEPTH; k++) begin
      t    = udiv64((t + dv) << 30, one_v + ((t * dv) >> 30));
      cur  = (t + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      r[k-1] = {TW'(cur - prev), TW'(prev)};
      prev = cur;
    end
    return r;
  endfunction

  localparam rom_t TROM = build_rom();
  localparam logic [TW-1:0] TLAST =
    TROM[TANH_TABLE_DEPTH-1][TW-1:0] + TROM[TANH_TABLE_DEPTH-1][2*TW-1:TW];

  logic [2*TW-1:0] rd;
  logic [QB-1:0]   frac_a;
  logic            sat_a;
  logic [SW-1:0]   side_a;
  logic            vld_a;
  logic [MW-1:0]   interp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd     <= TROM[in_idx];
      frac_a <= in_frac;
      sat_a  <= in_sat;
      side_a <= in_side;
    end
  end

  always_comb begin
    interp = MW'(rd[2*TW-1:TW]) * MW'(frac_a) + (MW'(1) << (QB - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tq   <= sat_a ? TLAST : rd[TW-1:0] + TW'(interp >> QB);
      out_side <= side_a;
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_highlight_soft_knee_rolloff_unit.sv @@
// Self-checking testbench for the highlight soft-knee roll-off unit.
`timescale 1ns / 1ps

// Scoreboard: predicts each rolled-off sample and checks results in order.
class rolloff_scoreboard;
  localparam int FRAC = 14;
  localparam int DEPTH = 256;
  localparam longint ONE = 64'sd1 << FRAC;

  longint tanh_lut[0:DEPTH];
  logic [hskr_pkg::AMOUNT_W-1:0] amount;
  logic signed [hskr_pkg::SAMPLE_W-1:0] pending_samples[$];
  int mismatches;

  function new();
    logic [63:0] one_hi, st, d, s2, s3, s5, s7, t;
    amount = '0;
    mismatches = 0;
    one_hi = 64'd1 << 30;
    st = (64'd4 << 30) / DEPTH;
    s2 = (st * st) >> 30;
    s3 = (s2 * st) >> 30;
    s5 = (s3 * s2) >> 30;
    s7 = (s5 * s2) >> 30;
    d = st - s3 / 3 + (2 * s5) / 15 - (17 * s7) / 315;
    t = 0;
    tanh_lut[0] = 0;
    // Step the tanh addition formula in Q30, round each entry to nearest in Q14.
    for (int i = 1; i <= DEPTH; i++) begin
      t = ((t + d) << 30) / (one_hi + ((t * d) >> 30));
      tanh_lut[i] = longint'((t + (64'd1 << (30 - FRAC - 1))) >> (30 - FRAC));
    end
  endfunction

  // Round to nearest, ties away from zero; den is positive.
  function longint round_div(longint num, longint den);
    longint m, q;
    m = num < 0 ? -num : num;
    q = (2 * m + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function longint tanh_interp(longint z);
    longint pos, idx, frac;
    if (z >= 4 * ONE) return tanh_lut[DEPTH];
    pos = z * DEPTH;
    idx = pos >>> (FRAC + 2);
    frac = pos & ((64'sd1 << (FRAC + 2)) - 1);
    return tanh_lut[idx] + round_div((tanh_lut[idx+1] - tanh_lut[idx]) * frac,
                                     64'sd1 << (FRAC + 2));
  endfunction

  function longint threshold();
    longint a;
    a = amount > 1024 ? 1024 : amount;
    return round_div(ONE * (8192 - 3 * a), 10240);
  endfunction

  function longint knee_width();
    longint a;
    a = amount > 1024 ? 1024 : amount;
    return round_div(ONE * (1536 + a), 10240);
  endfunction

  function logic signed [hskr_pkg::SAMPLE_W-1:0] rolloff(longint x);
    longint a, t, k, p, sc, c, r, u, z;
    a = amount > 1024 ? 1024 : amount;
    if (a == 0) begin
      r = x;
    end else begin
      t = threshold();
      k = knee_width();
      p = t + round_div(4 * k, 5);
      sc = ONE - p;
      if (x < t) begin
        c = x;
      end else if (x < t + k) begin
        u = x - t;
        c = t + u + round_div(u * u * (k - 2 * u), 5 * k * k);
      end else begin
        z = (2 * (x - t - k) * ONE) / sc;
        c = p + round_div(sc * tanh_interp(z), 2 * ONE);
      end
      r = x + round_div(a * (c - x), 1024);
    end
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[hskr_pkg::SAMPLE_W-1:0];
  endfunction

  function void note_sample(logic signed [hskr_pkg::SAMPLE_W-1:0] x);
    pending_samples.push_back(rolloff(longint'(x)));
  endfunction

  function void check_sample(logic signed [hskr_pkg::SAMPLE_W-1:0] got);
    logic signed [hskr_pkg::SAMPLE_W-1:0] want;
    if (pending_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result sample_out=%0d", got);
      return;
    end
    want = pending_samples.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch sample_out: expected %0d got %0d (amount %0d)",
                 want, got, amount);
    end
  endfunction
endclass

module tb_highlight_soft_knee_rolloff_unit;
  import hskr_pkg::*;

  // Pipeline depth plus margin; used for the drain wait before writes and at the end.
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [AMOUNT_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // [17:0] sample_in
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [17:0] sample_out

  // Random idle bursts on both sides; cleared for the final phase.
  bit idling = 1'b1;
  rolloff_scoreboard sb;

  highlight_soft_knee_rolloff_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Watch both handshakes: note each accepted input, check each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata[SAMPLE_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata[SAMPLE_W-1:0]);
    end
  end

  // Hold one sample on the slave side until it is taken, after an optional gap.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= TDATA_W'(x[SAMPLE_W-1:0]);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid, wait for every result to come out, then let the pipeline drain.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the amount register while the block is idle.
  task automatic write_amount(input logic [AMOUNT_W-1:0] v);
    drain_pipeline();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.amount = v;
  endtask

  // Random sample: mostly around the knee and tail, some anywhere in range.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1: return SAMPLE_W'($urandom);
      2: return SAMPLE_W'($urandom_range(0, 131071));
      default: return SAMPLE_W'($urandom_range(6000, 40000));
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  // Master side: ready most of the time, with random stall bursts.
  initial begin
    @(negedge rst);
    forever begin
      if (idling && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    longint t, k;
    logic [AMOUNT_W-1:0] amounts[7] = '{11'd1024, 11'd1, 11'd512, 11'd2047,
                                        11'd1025, 11'd300, 11'd0};
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: amount zero passes everything, then extremes at a mid amount.
    send_sample(-18'sd131072);
    send_sample(18'sd131071);
    send_sample(18'sd16384);
    write_amount(11'd700);
    t = sb.threshold();
    k = sb.knee_width();
    send_sample(-18'sd131072);
    send_sample(18'sd131071);
    send_sample(18'sd0);
    send_sample(-18'sd1);
    send_sample(18'sd1);
    send_sample(SAMPLE_W'(t - 1));
    send_sample(SAMPLE_W'(t));
    send_sample(SAMPLE_W'(t + 1));
    send_sample(SAMPLE_W'(t + k / 2));
    send_sample(SAMPLE_W'(t + k - 1));
    send_sample(SAMPLE_W'(t + k));
    send_sample(SAMPLE_W'(t + k + 1));
    send_sample(18'sd16384);
    send_sample(18'sd30000);
    send_sample(18'sd65536);    // far above the knee, past the end of the table
    send_sample(18'sd100000);
    send_sample(18'h2AAAA);
    send_sample(18'h15555);

    // Pause mid-stream until every expected result is out.
    run_random(40);
    drain_pipeline();
    run_random(60);

    // Random phases at several amounts, extremes included.
    foreach (amounts[i]) begin
      write_amount(amounts[i]);
      run_random(130);
    end
    for (int p = 0; p < 3; p++) begin
      write_amount(AMOUNT_W'($urandom_range(0, 2047)));
      run_random(130);
    end

    // Final phase without idling on either side.
    write_amount(11'd850);
    idling = 1'b0;
    run_random(130);

    drain_pipeline();
    if (sb.mismatches == 0 && sb.pending_samples.size() == 0) begin
      $display("PASS highlight_soft_knee_rolloff_unit");
    end else begin
      $display("FAIL highlight_soft_knee_rolloff_unit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("FAIL highlight_soft_knee_rolloff_unit");
    $finish;
  end
endmodule
